FILE: rtl/core/rotary_detent_accumulator_macros.svh
// Assertion macros used by the detent accumulator checker.
`ifndef ROTARY_DETENT_ACCUMULATOR_MACROS_SVH
`define ROTARY_DETENT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define RDA_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("rda check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define RDA_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rda check failed");

`endif

FILE: rtl/core/rda_pkg.sv
// Shared types and codes for the rotary detent accumulator.
package rda_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_POST,
        ST_FIN
    } state_t;

    // config register indexes
    localparam logic [7:0] CFG_DETENT_TICKS = 8'd0;
    localparam logic [7:0] CFG_START_COUNT  = 8'd1;

    // move codes
    localparam logic [1:0] MOVE_NONE = 2'd0;
    localparam logic [1:0] MOVE_NEXT = 2'd1;
    localparam logic [1:0] MOVE_PREV = 2'd2;

    localparam logic [6:0] DETENT_RESET = 7'd4;

    // divider result as seen by the controller
    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
        logic [6:0]  remainder;
    } div_res_t;

endpackage

FILE: rtl/core/rda_serial_div.sv
// Radix-2 restoring divider: 16-bit magnitude by 7-bit divisor, one bit per cycle.
module rda_serial_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [15:0]      dividend,
    input  logic [6:0]       divisor,
    output rda_pkg::div_res_t res
);
    import rda_pkg::*;

    logic        active_reg;
    logic        done_reg;
    logic [3:0]  cnt_reg;
    logic [15:0] quo_reg;
    logic [6:0]  rem_reg;
    logic [6:0]  dvs_reg;
    logic [7:0]  trial;
    logic        ge;

    // shift next dividend bit into partial remainder, try subtract
    assign trial = {rem_reg, quo_reg[15]};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= 4'd0;
        end
        else
        begin
            done_reg <= active_reg && (cnt_reg == 4'd0);
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= 4'd15;
            end
            else if (active_reg)
            begin
                if (cnt_reg == 4'd0)
                begin
                    active_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 7'd0;
            dvs_reg <= divisor;
        end
        else if (active_reg)
        begin
            quo_reg <= {quo_reg[14:0], ge};
            rem_reg <= ge ? 7'(trial - {1'b0, dvs_reg}) : trial[6:0];
        end
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule

FILE: rtl/core/rotary_detent_accumulator.sv
// Top level: rotary encoder detent accumulator with serial detent divider.
// Polls are handled one at a time: a new input beat is taken only in idle, after the
//   previous result is loaded into the output register or the output is free.
// Long path through the 16-step bit-serial divider on a counter poll with motion;
//   short path when the poll carries no count flag or no counter change. Output register frees the input side.
// Reset: detent_ticks = 4, last sample, remainder and backlog cleared, no beat held.
module rotary_detent_accumulator (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] counter_value
    input  logic [1:0]  s_tuser,   // [0] button_event, [1] count_event
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] pending_steps (two's complement)
    output logic [2:0]  m_tuser,   // [0] enter_action, [2:1] move_action
    // config write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import rda_pkg::*;

    state_t state_reg, state_next;

    // architectural state
    logic [6:0]         detent_reg;
    logic [15:0]        last_sample_reg;
    logic signed [7:0]  partial_reg;
    logic signed [15:0] backlog_reg;
    logic signed [15:0] prev_reg;     // backlog before this poll

    // captured input beat
    logic        button_reg;
    logic        count_reg;
    logic [15:0] sample_reg;
    logic        neg_reg;             // sign of the tick sum being divided

    // output register
    logic        m_tvalid_reg, m_tvalid_next;
    logic [15:0] m_tdata_reg;
    logic [2:0]  m_tuser_reg;

    // control strobes
    logic in_take;
    logic div_start;
    logic fin_load;
    logic out_free;

    // PREP datapath
    logic signed [15:0] delta;
    logic               reversal;
    logic signed [7:0]  partial_eff;
    logic signed [16:0] sum;
    logic [16:0]        sum_neg;
    logic [15:0]        sum_mag;
    logic [6:0]         divisor;
    logic               motion;

    // POST datapath
    logic signed [16:0] q_signed;
    logic signed [17:0] acc;
    logic signed [15:0] backlog_sat;
    logic [7:0]         rem_signed;

    // FIN datapath
    logic               changed;
    logic [1:0]         move;
    logic signed [15:0] backlog_fin;

    div_res_t div_res;

    assign cfg_ready = 1'b1;          // user must have config arrive only while idle; the block does not enforce it
    assign out_free  = !m_tvalid_reg || m_tready;
    assign in_take   = s_tvalid && s_tready;

    // ---- poll preparation: wrapped delta, reversal clear, tick sum ----
    assign delta       = signed'(sample_reg - last_sample_reg);
    assign reversal    = (partial_reg > 8'sd0 && delta < 16'sd0) ||
                         (partial_reg < 8'sd0 && delta > 16'sd0);
    assign partial_eff = reversal ? 8'sd0 : partial_reg;
    assign sum         = {{9{partial_eff[7]}}, partial_eff} + {delta[15], delta};
    assign sum_neg     = 17'(-sum);
    assign sum_mag     = sum[16] ? sum_neg[15:0] : sum[15:0];  // max 32894 fits
    assign divisor     = (detent_reg == 7'd0) ? 7'd1 : detent_reg;
    assign motion      = count_reg && (delta != 16'sd0);

    rda_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (divisor),
        .res      (div_res)
    );

    // ---- quotient fold-in with 16-bit saturation ----
    assign q_signed = neg_reg ? 17'(-{1'b0, div_res.quotient}) : {1'b0, div_res.quotient};
    assign acc      = {{2{backlog_reg[15]}}, backlog_reg} + {q_signed[16], q_signed};

    always_comb
    begin
        if (!acc[17] && (acc[16:15] != 2'b00))
        begin
            backlog_sat = 16'sh7fff;
        end
        else if (acc[17] && (acc[16:15] != 2'b11))
        begin
            backlog_sat = 16'sh8000;
        end
        else
        begin
            backlog_sat = acc[15:0];
        end
    end

    // remainder takes the sign of the sum (truncating division)
    assign rem_signed = neg_reg ? 8'(-{1'b0, div_res.remainder}) : {1'b0, div_res.remainder};

    // ---- move decision: one step toward zero when backlog changed and is nonzero ----
    assign changed = (backlog_reg != prev_reg) && (backlog_reg != 16'sd0);

    always_comb
    begin
        move        = MOVE_NONE;
        backlog_fin = backlog_reg;
        if (changed)
        begin
            if (!backlog_reg[15])
            begin
                move        = MOVE_NEXT;
                backlog_fin = backlog_reg - 16'sd1;
            end
            else
            begin
                move        = MOVE_PREV;
                backlog_fin = backlog_reg + 16'sd1;
            end
        end
    end

    // ---- sequencer: next state ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = motion ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ---- sequencer: strobes ----
    always_comb
    begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        fin_load  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_PREP:
            begin
                div_start = motion;
            end
            ST_FIN:
            begin
                fin_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (fin_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_tvalid_reg    <= 1'b0;
            detent_reg      <= DETENT_RESET;
            last_sample_reg <= 16'd0;
            partial_reg     <= 8'sd0;
            backlog_reg     <= 16'sd0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_DETENT_TICKS)
                begin
                    detent_reg <= cfg_data[6:0];
                end
                else if (cfg_index == CFG_START_COUNT)
                begin
                    last_sample_reg <= cfg_data;
                end
            end

            if (div_start)
            begin
                last_sample_reg <= sample_reg;
            end

            if (state_reg == ST_POST)
            begin
                backlog_reg <= backlog_sat;
                partial_reg <= signed'(rem_signed);
            end

            if (fin_load)
            begin
                backlog_reg <= backlog_fin;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            button_reg <= s_tuser[0];
            count_reg  <= s_tuser[1];
            sample_reg <= s_tdata;
        end
        if (state_reg == ST_PREP)
        begin
            prev_reg <= backlog_reg;
            neg_reg  <= sum[16];
        end
        if (fin_load)
        begin
            m_tdata_reg <= backlog_fin;
            m_tuser_reg <= {move, button_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: rtl/core/rda_checker.sv
// Port-level checker for the rotary detent accumulator, bound to the top level.
`include "rotary_detent_accumulator_macros.svh"

module rda_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [2:0]  m_tuser
);
    import rda_pkg::*;

    // stalled result beat holds
    `RDA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

    // one poll in flight at a time
    `RDA_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)

    // a next move leaves a non-negative backlog
    `RDA_ASSERT_NOW(a_next_nonneg, m_tvalid && (m_tuser[2:1] == MOVE_NEXT), !m_tdata[15])

    // a prev move leaves a non-positive backlog
    `RDA_ASSERT_NOW(a_prev_nonpos, m_tvalid && (m_tuser[2:1] == MOVE_PREV), m_tdata[15] || (m_tdata == 16'd0))

endmodule

bind rotary_detent_accumulator rda_checker u_rda_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
